>>> hdl/lifo_stack_with_search_top_macros.svh
// Assertion macros for the LIFO stack with search.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LIFO_STACK_WITH_SEARCH_TOP_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_TOP_MACROS_SVH

// same-cycle implication, idle during reset
`define LSS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/lss_pkg.sv
// Shared types, codes and constants of the LIFO stack with search.
// No dependencies.
package lss_pkg;

	localparam int DATA_W      = 32;
	localparam int ACTION_W    = 3;
	localparam int STATUS_W    = 2;
	localparam int INDEX_W     = 6;
	localparam int FILL_W      = 7;
	localparam int CAP_W       = 7;
	localparam int DEPTH_DEFAULT = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

	localparam logic [ACTION_W-1:0] ACT_PUSH   = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_POP    = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	localparam logic signed [DATA_W-1:0] VALUE_NONE = '1;

	typedef struct packed {
		logic [ACTION_W-1:0]      action;
		logic signed [DATA_W-1:0] data_word;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value_out;
		logic [INDEX_W-1:0]       found_index;
		logic [STATUS_W-1:0]      status;
		logic [FILL_W-1:0]        fill_count;
	} rsp_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic push;   // take the upper neighbor's word
		logic pop;    // take the lower neighbor's word
		logic load;   // latch key compare into match flag
		logic scan;   // take the lower neighbor's match flag
	} cell_ctl_t;

endpackage

>>> hdl/lss_cell.sv
// One stack cell: holds a word and a search match flag.
// Depends on lss_pkg.
module lss_cell
	import lss_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  cell_ctl_t                ctl,
	input  logic                     valid,
	input  logic signed [DATA_W-1:0] key,
	input  logic signed [DATA_W-1:0] upper,
	input  logic signed [DATA_W-1:0] lower,
	input  logic                     lower_match,
	output logic signed [DATA_W-1:0] value,
	output logic                     match
);

	logic signed [DATA_W-1:0] value_q;
	logic                     match_q;

	// push and pop never come together; the word holds otherwise
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= upper;
		end else if (ctl.pop) begin
			value_q <= lower;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.load) begin
			match_q <= valid && (value_q == key);
		end else if (ctl.scan) begin
			match_q <= lower_match;
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

>>> hdl/lifo_stack_with_search_top.sv
// LIFO stack with search: a row of cells, cell 0 holds the top of stack.
// Push, pop, peek, clear: result registered at accept; accepted while no search runs and the skid is free.
// Search: all cells compare the key at once, then the match flags shift toward
// cell 0 one per cycle until a hit reaches cell 0 or the scan ends (topmost hit first).
// Two-deep result queue; reset (arst_n low) empties the stack and queue and
// sets capacity to 64. Cell words are not reset.
module lifo_stack_with_search_top
	import lss_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > FILL_W) ? CW : FILL_W;

	logic [CW-1:0]    cnt_q, cnt_d;
	logic [CW-1:0]    scan_q, scan_d;
	logic             busy_q, busy_d;
	logic [CAP_W-1:0] cap_q;

	logic [CMPW-1:0]  cnt_ext, cnt_d_ext, eff_cap, cap_ext, hit_idx;
	logic             req_fire, rsp_fire, full, empty, scan_last;
	logic             res_fire;
	rsp_t             res;
	cell_ctl_t        ctl;

	logic                     head_valid_q, skid_valid_q;
	rsp_t                     head_q, skid_q;

	logic signed [DATA_W-1:0] value_v [DEPTH];
	logic                     match_v [DEPTH];
	logic                     valid_v [DEPTH];

	assign req_fire  = req_valid && req_ready;
	assign rsp_fire  = head_valid_q && rsp_ready;
	assign req_ready = !busy_q && !skid_valid_q;
	assign rsp_valid = head_valid_q;
	assign rsp       = head_q;

	assign cnt_ext   = CMPW'(cnt_q);
	assign cnt_d_ext = CMPW'(cnt_d);
	assign cap_ext   = CMPW'(cap_q);
	assign eff_cap   = (cap_ext > CMPW'(DEPTH)) ? CMPW'(DEPTH) : cap_ext;
	assign full      = cnt_ext >= eff_cap;
	assign empty     = (cnt_q == '0);
	assign scan_last = (scan_q == cnt_q - CW'(1));
	// scan step k looks at stack entry fill-1-k
	assign hit_idx   = cnt_ext - CMPW'(scan_q) - CMPW'(1);

	always_comb begin
		ctl      = '0;
		cnt_d    = cnt_q;
		busy_d   = busy_q;
		scan_d   = scan_q;
		res_fire = 1'b0;
		res      = '{value_out: VALUE_NONE, found_index: '0, status: ST_OK,
		             fill_count: '0};
		if (busy_q) begin
			if (match_v[0]) begin
				res_fire        = 1'b1;
				busy_d          = 1'b0;
				res.found_index = hit_idx[INDEX_W-1:0];
			end else if (scan_last) begin
				res_fire   = 1'b1;
				busy_d     = 1'b0;
				res.status = ST_NOT_FOUND;
			end else begin
				ctl.scan = 1'b1;
				scan_d   = scan_q + CW'(1);
			end
		end else if (req_fire) begin
			res_fire = 1'b1;
			unique case (req.action)
				ACT_PUSH: begin
					if (full) begin
						res.status = ST_FULL;
					end else begin
						ctl.push = 1'b1;
						cnt_d    = cnt_q + CW'(1);
					end
				end
				ACT_POP: begin
					if (empty) begin
						res.status = ST_EMPTY;
					end else begin
						ctl.pop       = 1'b1;
						cnt_d         = cnt_q - CW'(1);
						res.value_out = value_v[0];
					end
				end
				ACT_PEEK: begin
					if (empty) begin
						res.status = ST_EMPTY;
					end else begin
						res.value_out = value_v[0];
					end
				end
				ACT_CLEAR: begin
					cnt_d = '0;
				end
				ACT_SEARCH: begin
					if (empty) begin
						res.status = ST_NOT_FOUND;
					end else begin
						res_fire = 1'b0;
						ctl.load = 1'b1;
						busy_d   = 1'b1;
						scan_d   = '0;
					end
				end
				default: ;
			endcase
		end
		res.fill_count = cnt_d_ext[FILL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			scan_q <= '0;
			cap_q  <= CAP_RESET;
		end else begin
			cnt_q  <= cnt_d;
			busy_q <= busy_d;
			scan_q <= scan_d;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
		end
	end

	// result queue: head drives the port, skid catches one more while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!head_valid_q) begin
				head_valid_q <= res_fire;
			end else if (rsp_fire) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
				end else begin
					head_valid_q <= res_fire;
				end
			end else if (res_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!head_valid_q || (rsp_fire && !skid_valid_q)) begin
			head_q <= res;
		end else if (rsp_fire) begin
			head_q <= skid_q;
		end
		if (head_valid_q && !rsp_fire && res_fire) begin
			skid_q <= res;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [DATA_W-1:0] upper, lower;
		logic                     lower_match;

		if (i == 0) begin : g_top
			assign upper = req.data_word;
		end else begin : g_mid
			assign upper = value_v[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign lower       = '0;
			assign lower_match = 1'b0;
		end else begin : g_next
			assign lower       = value_v[i+1];
			assign lower_match = match_v[i+1];
		end

		assign valid_v[i] = CMPW'(i) < cnt_ext;

		lss_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.valid       (valid_v[i]),
			.key         (req.data_word),
			.upper       (upper),
			.lower       (lower),
			.lower_match (lower_match),
			.value       (value_v[i]),
			.match       (match_v[i])
		);
	end

`include "lifo_stack_with_search_top_macros.svh"

	`LSS_ASSERT_NOW(a_fill_bound, 1'b1, cnt_ext <= CMPW'(DEPTH), "fill above depth")
	`LSS_ASSERT_NOW(a_busy_nonempty, busy_q, !empty && (scan_q < cnt_q), "scan out of range")
	`LSS_ASSERT_NOW(a_skid_order, skid_valid_q, head_valid_q, "skid held without head")
	`LSS_ASSERT_NEXT(a_push_grows, req_fire && (req.action == ACT_PUSH) && !full, cnt_q == $past(cnt_q) + CW'(1), "push did not grow fill")

endmodule
